/* hdl/cbf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants and types of the cubic Bezier flattener.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int MAX_DEPTH   = 6;           // subdivision levels before a forced line
    localparam int COORD_WIDTH = 32;          // internal coordinate width
    localparam int GB_ONE      = 65536;       // 1.0 in Q16.16
    localparam int IO_WIDTH    = 32;          // width of the coordinate ports
    localparam int LIMIT_WIDTH = 31;
    localparam int STACK_SLOTS = 8;
    localparam int SLOT_BITS   = 3;
    localparam int SP_BITS     = 4;
    localparam int LEVEL_BITS  = 3;
    localparam int PT_WORDS    = 8;
    localparam int ERR_WIDTH   = COORD_WIDTH + 3;
    localparam int MIN_WIDTH   = COORD_WIDTH + 2;
    localparam int SUM_WIDTH   = (COORD_WIDTH + 3 > LIMIT_WIDTH) ? COORD_WIDTH + 3 : LIMIT_WIDTH;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(GB_ONE);
    localparam logic [0:0] REG_FLATNESS_LIMIT = 1'b0;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        logic                  load_in;
        logic                  meas_a;
        logic                  meas_b;
        logic                  split_a;
        logic                  split_b;
        logic                  split_c;
        logic                  push;
        logic                  pop_rd;
        logic                  pop_ld;
        logic                  emit;
        logic [SLOT_BITS-1:0]  addr;
        logic [LEVEL_BITS-1:0] push_level;
    } t_dp_cmd;

    typedef struct packed {
        logic                  flat_small;
        logic [LEVEL_BITS-1:0] pop_level;
    } t_dp_stat;

endpackage
`default_nettype wire

/* hdl/cbf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_datapath
// Current piece, flatness measure, midpoint split and the stack of right halves.
// ----------------------------------------------------------------------------
module cbf_datapath import cbf_pkg::*; (
    input  wire logic                    i_clk,
    input  wire t_dp_cmd                 i_cmd,
    input  wire logic [LIMIT_WIDTH-1:0]  i_limit,
    input  wire logic [IO_WIDTH-1:0]     i_pts [PT_WORDS],
    output t_dp_stat                     o_stat,
    output logic signed [IO_WIDTH-1:0]   o_line_to_x,
    output logic signed [IO_WIDTH-1:0]   o_line_to_y
);

    localparam int WORD_BITS = PT_WORDS * COORD_WIDTH;

    t_coord r_cur [PT_WORDS];
    logic signed [ERR_WIDTH-1:0] r_eb [2];
    logic signed [ERR_WIDTH-1:0] r_ee [2];
    logic [MIN_WIDTH-1:0] r_mn [2];
    t_coord r_mid [2];
    t_coord r_l1 [2];
    t_coord r_r2 [2];
    t_coord r_l2 [2];
    t_coord r_r1 [2];
    logic [WORD_BITS-1:0] r_mem [STACK_SLOTS];
    logic [LEVEL_BITS-1:0] r_lvl_mem [STACK_SLOTS];
    logic [WORD_BITS-1:0] r_rd;
    logic [LEVEL_BITS-1:0] r_rd_lvl;
    logic signed [IO_WIDTH-1:0] r_out_x;
    logic signed [IO_WIDTH-1:0] r_out_y;

    logic [WORD_BITS-1:0] n_right;
    logic [SUM_WIDTH-1:0] n_sum;
    t_coord n_m [2];

    function automatic t_coord half(input t_coord a, input t_coord b);
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        return s[COORD_WIDTH:1];
    endfunction

    function automatic logic signed [ERR_WIDTH-1:0] sx(input t_coord c);
        return {{3{c[COORD_WIDTH-1]}}, c};
    endfunction

    function automatic t_coord from_io(input logic [IO_WIDTH-1:0] v);
        logic [COORD_WIDTH+IO_WIDTH-1:0] e;
        e = {{COORD_WIDTH{v[IO_WIDTH-1]}}, v};
        return e[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [IO_WIDTH-1:0] to_io(input t_coord c);
        logic [COORD_WIDTH+IO_WIDTH-1:0] e;
        e = {{IO_WIDTH{c[COORD_WIDTH-1]}}, c};
        return e[IO_WIDTH-1:0];
    endfunction

    function automatic logic [MIN_WIDTH-1:0] mag(input logic signed [ERR_WIDTH-1:0] v);
        logic signed [ERR_WIDTH-1:0] a;
        a = v[ERR_WIDTH-1] ? -v : v;
        return a[MIN_WIDTH-1:0];
    endfunction

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_m[a] = half(r_l2[a], r_r1[a]);
        end
        // right half: m r1 r2 p3, word k at bits k*COORD_WIDTH
        n_right = {r_cur[7], r_cur[6], r_r2[1], r_r2[0], r_r1[1], r_r1[0], n_m[1], n_m[0]};
        n_sum = SUM_WIDTH'(r_mn[0]) + SUM_WIDTH'(r_mn[1]);
    end

    assign o_stat.flat_small = (n_sum <= SUM_WIDTH'(i_limit));
    assign o_stat.pop_level  = r_rd_lvl;
    assign o_line_to_x = r_out_x;
    assign o_line_to_y = r_out_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int k = 0; k < PT_WORDS; k++) begin
                r_cur[k] <= from_io(i_pts[k]);
            end
        end
        if (i_cmd.pop_ld) begin
            for (int k = 0; k < PT_WORDS; k++) begin
                r_cur[k] <= r_rd[k*COORD_WIDTH +: COORD_WIDTH];
            end
        end
        if (i_cmd.meas_a) begin
            for (int a = 0; a < 2; a++) begin
                r_eb[a] <= sx(r_cur[2+a]) + (sx(r_cur[2+a]) <<< 1)
                           - (sx(r_cur[a]) <<< 1) - sx(r_cur[6+a]);
                r_ee[a] <= sx(r_cur[4+a]) + (sx(r_cur[4+a]) <<< 1)
                           - (sx(r_cur[6+a]) <<< 1) - sx(r_cur[a]);
            end
        end
        if (i_cmd.meas_b) begin
            for (int a = 0; a < 2; a++) begin
                r_mn[a] <= (mag(r_ee[a]) < mag(r_eb[a])) ? mag(r_ee[a]) : mag(r_eb[a]);
            end
        end
        if (i_cmd.split_a) begin
            for (int a = 0; a < 2; a++) begin
                r_mid[a] <= half(r_cur[2+a], r_cur[4+a]);
                r_l1[a]  <= half(r_cur[a], r_cur[2+a]);
                r_r2[a]  <= half(r_cur[4+a], r_cur[6+a]);
            end
        end
        if (i_cmd.split_b) begin
            for (int a = 0; a < 2; a++) begin
                r_l2[a] <= half(r_mid[a], r_l1[a]);
                r_r1[a] <= half(r_mid[a], r_r2[a]);
            end
        end
        if (i_cmd.split_c) begin
            // keep the left half: p0 l1 l2 m
            for (int a = 0; a < 2; a++) begin
                r_cur[2+a] <= r_l1[a];
                r_cur[4+a] <= r_l2[a];
                r_cur[6+a] <= n_m[a];
            end
        end
        if (i_cmd.push) begin
            r_mem[i_cmd.addr]     <= n_right;
            r_lvl_mem[i_cmd.addr] <= i_cmd.push_level;
        end
        if (i_cmd.pop_rd) begin
            r_rd     <= r_mem[i_cmd.addr];
            r_rd_lvl <= r_lvl_mem[i_cmd.addr];
        end
        if (i_cmd.emit) begin
            r_out_x <= to_io(r_cur[6]);
            r_out_y <= to_io(r_cur[7]);
        end
    end

endmodule
`default_nettype wire

/* hdl/cbf_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_controller
// Sequencer of the subdivision: measure, split or emit, pop.
// ----------------------------------------------------------------------------
module cbf_controller import cbf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output logic          o_last_segment,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAS_A, ST_MEAS_B, ST_DECIDE, ST_SPLIT_A, ST_SPLIT_B,
        ST_SPLIT_C, ST_EMIT, ST_POP_RD, ST_POP_LD
    } t_state;

    t_state r_state;
    logic [SP_BITS-1:0] r_sp;
    logic [LEVEL_BITS-1:0] r_level;
    logic r_out_valid;
    logic r_last;
    logic n_free;

    assign n_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_last_segment = r_last;

    always_comb begin
        o_cmd = '0;
        o_cmd.push_level = r_level + 1'b1;
        o_cmd.addr = r_sp[SLOT_BITS-1:0];
        unique case (r_state)
            ST_IDLE:    o_cmd.load_in = i_in_valid;
            ST_MEAS_A:  o_cmd.meas_a = 1'b1;
            ST_MEAS_B:  o_cmd.meas_b = 1'b1;
            ST_SPLIT_A: o_cmd.split_a = 1'b1;
            ST_SPLIT_B: o_cmd.split_b = 1'b1;
            ST_SPLIT_C: begin
                o_cmd.split_c = 1'b1;
                o_cmd.push = (r_sp < SP_BITS'(STACK_SLOTS));
            end
            ST_EMIT:    o_cmd.emit = n_free;
            ST_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                o_cmd.addr = r_sp[SLOT_BITS-1:0] - 1'b1;
            end
            ST_POP_LD:  o_cmd.pop_ld = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sp <= '0;
            r_level <= '0;
            r_out_valid <= 1'b0;
            r_last <= 1'b0;
        end else begin
            // drop the valid once taken; the emit state refills it itself
            if (r_out_valid && i_out_ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_sp <= '0;
                        r_level <= '0;
                        r_state <= ST_MEAS_A;
                    end
                end
                ST_MEAS_A: r_state <= ST_MEAS_B;
                ST_MEAS_B: r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (r_level >= LEVEL_BITS'(MAX_DEPTH) || i_stat.flat_small) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_SPLIT_A;
                    end
                end
                ST_SPLIT_A: r_state <= ST_SPLIT_B;
                ST_SPLIT_B: r_state <= ST_SPLIT_C;
                ST_SPLIT_C: begin
                    r_level <= r_level + 1'b1;
                    if (r_sp < SP_BITS'(STACK_SLOTS)) begin
                        r_sp <= r_sp + 1'b1;
                    end
                    r_state <= ST_MEAS_A;
                end
                ST_EMIT: begin
                    if (n_free) begin
                        r_out_valid <= 1'b1;
                        r_last <= (r_sp == '0);
                        r_state <= (r_sp == '0) ? ST_IDLE : ST_POP_RD;
                    end
                end
                ST_POP_RD: begin
                    r_sp <= r_sp - 1'b1;
                    r_state <= ST_POP_LD;
                end
                ST_POP_LD: begin
                    r_level <= i_stat.pop_level;
                    r_state <= ST_MEAS_A;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hdl/cubic_bezier_flattener.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Adaptive de Casteljau flattening of one cubic curve into line end points.
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_ready     i_start_*, i_ctrl1_*, i_ctrl2_*, i_end_*
// output    out        o_out_valid / i_out_ready   o_line_to_x/y, o_last_segment
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// Each piece is measured (MEAS_A, MEAS_B, DECIDE), then either split (SPLIT_A,
// SPLIT_B, SPLIT_C) or emitted and, unless it is the last, followed by a stack
// pop (POP_RD, POP_LD). The sequencer serialises measure and split through one
// shared datapath, and a new curve is taken only once the current one is done.
// Reset is synchronous and clears the sequencer, stack pointer and output valid;
// the stack needs no clearing. A stalled output holds its transaction while the
// next curve may already be taken once the last segment sits in the register.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener import cbf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic signed [31:0]    i_start_x,
    input  wire logic signed [31:0]    i_start_y,
    input  wire logic signed [31:0]    i_ctrl1_x,
    input  wire logic signed [31:0]    i_ctrl1_y,
    input  wire logic signed [31:0]    i_ctrl2_x,
    input  wire logic signed [31:0]    i_ctrl2_y,
    input  wire logic signed [31:0]    i_end_x,
    input  wire logic signed [31:0]    i_end_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [31:0]         o_line_to_x,
    output logic signed [31:0]         o_line_to_y,
    output logic                       o_last_segment,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [LIMIT_WIDTH-1:0] r_limit;
    logic [IO_WIDTH-1:0] n_pts [PT_WORDS];
    t_dp_cmd n_cmd;
    t_dp_stat n_stat;

    // Register index is the word address; only the limit exists.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FLATNESS_LIMIT) ? {1'b0, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_FLATNESS_LIMIT) begin
            r_limit <= pwdata[LIMIT_WIDTH-1:0];
        end
    end

    // Gather the curve in point order: p0, c1, c2, p3, x before y.
    assign n_pts[0] = i_start_x;
    assign n_pts[1] = i_start_y;
    assign n_pts[2] = i_ctrl1_x;
    assign n_pts[3] = i_ctrl1_y;
    assign n_pts[4] = i_ctrl2_x;
    assign n_pts[5] = i_ctrl2_y;
    assign n_pts[6] = i_end_x;
    assign n_pts[7] = i_end_y;

    cbf_controller u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_last_segment (o_last_segment),
        .o_cmd          (n_cmd),
        .i_stat         (n_stat)
    );

    cbf_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (n_cmd),
        .i_limit     (r_limit),
        .i_pts       (n_pts),
        .o_stat      (n_stat),
        .o_line_to_x (o_line_to_x),
        .o_line_to_y (o_line_to_y)
    );

endmodule
`default_nettype wire

/* dv/cubic_bezier_flattener_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_tb
// Self-checking bench for the Bezier flattener: random and corner curves are
// driven in bursts, line end points are checked against a local subdivision
// model, and the flatness limit is swept through several values.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_tb;
    import cbf_pkg::*;

    typedef struct {
        logic signed [31:0] c [8];  // p0x p0y c1x c1y c2x c2y p3x p3y
    } t_curve;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } t_point;

    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic signed [31:0] pt [8];
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire in_ready, out_valid, last_seg, pready;
    wire signed [31:0] line_x, line_y;
    wire [31:0] prdata;

    t_curve curve_queue [$];
    t_point segment_queue [$];
    logic [LIMIT_WIDTH-1:0] model_limit = LIMIT_RESET;
    int  errors = 0;
    int  segments_seen = 0;
    int  curves_sent = 0;
    longint cycle_count = 0;
    bit  long_hold = 1'b0;     // request a long receiver hold-off
    bit  in_taken = 1'b0;      // offered transaction has been accepted
    int  burst_left = 0, gap_left = 0;

    always #4 i_clk = ~i_clk;

    cubic_bezier_flattener dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_start_x(pt[0]), .i_start_y(pt[1]), .i_ctrl1_x(pt[2]), .i_ctrl1_y(pt[3]),
        .i_ctrl2_x(pt[4]), .i_ctrl2_y(pt[5]), .i_end_x(pt[6]), .i_end_y(pt[7]),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_line_to_x(line_x), .o_line_to_y(line_y), .o_last_segment(last_seg),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial foreach (pt[i]) pt[i] = '0;

    // Floor-halved sum; 64-bit is ample for 32-bit coordinates.
    function automatic longint halve(longint a, longint b);
        longint s;
        s = a + b;
        return s >>> 1;
    endfunction

    function automatic longint flatness(longint c [8]);
        longint sum, mb, me;
        sum = 0;
        for (int a = 0; a < 2; a++) begin
            mb = 3 * c[2+a] - 2 * c[a] - c[6+a];
            me = 3 * c[4+a] - 2 * c[6+a] - c[a];
            if (mb < 0) mb = -mb;
            if (me < 0) me = -me;
            sum += (me < mb) ? me : mb;
        end
        return sum;
    endfunction

    // Subdivide one curve and queue the end points it must produce.
    task automatic predict_segments(t_curve cv);
        longint cur [8], lft [8], rgt [8];
        longint held [8][8];
        int     held_lvl [8];
        int     depth, lvl;
        longint mid, l1, r2, l2, r1, m;
        t_point p;
        for (int i = 0; i < 8; i++) cur[i] = cv.c[i];
        depth = 0;
        lvl = 0;
        forever begin
            if (lvl >= MAX_DEPTH || flatness(cur) <= longint'(model_limit)) begin
                p.x = cur[6][31:0];
                p.y = cur[7][31:0];
                p.last = (depth == 0);
                segment_queue.push_back(p);
                if (depth == 0) break;
                depth--;
                cur = held[depth];
                lvl = held_lvl[depth];
            end else begin
                for (int a = 0; a < 2; a++) begin
                    mid = halve(cur[2+a], cur[4+a]);
                    l1  = halve(cur[a], cur[2+a]);
                    r2  = halve(cur[4+a], cur[6+a]);
                    l2  = halve(mid, l1);
                    r1  = halve(mid, r2);
                    m   = halve(l2, r1);
                    lft[a] = cur[a]; lft[2+a] = l1; lft[4+a] = l2; lft[6+a] = m;
                    rgt[a] = m; rgt[2+a] = r1; rgt[4+a] = r2; rgt[6+a] = cur[6+a];
                end
                lvl++;
                if (depth < 8) begin
                    held[depth] = rgt;
                    held_lvl[depth] = lvl;
                    depth++;
                end
                cur = lft;
            end
        end
    endtask

    // Driver: offer curves in bursts, change inputs on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_valid && !in_taken)) begin
            // previous transaction went through (or none was offered)
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            if (gap_left > 0 && curve_queue.size() > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (curve_queue.size() > 0) begin
                t_curve cv;
                cv = curve_queue.pop_front();
                foreach (pt[i]) pt[i] <= cv.c[i];
                in_valid <= 1'b1;
                in_taken = 1'b0;
                if (burst_left > 0) burst_left--;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    int hold_count = 0;
    always @(negedge i_clk) begin
        if (long_hold && hold_count == 0) hold_count = 400;
        if (hold_count > 0) begin
            hold_count--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 9) < ((cycle_count / 2000) % 2 ? 10 : 6));
        end
    end

    // Monitor: predict on accepted curves, check accepted points.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d points outstanding", $time, segment_queue.size());
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && in_valid && in_ready) begin
            t_curve cv;
            foreach (pt[i]) cv.c[i] = pt[i];
            predict_segments(cv);
            curves_sent++;
            in_taken = 1'b1;
        end
        if (i_rst_n && out_valid && out_ready) begin
            segments_seen++;
            if (segment_queue.size() == 0) begin
                errors++;
                $display("%0t unexpected point x=%h y=%h last=%b", $time,
                         line_x, line_y, last_seg);
            end else begin
                t_point e;
                e = segment_queue.pop_front();
                if (line_x !== e.x || line_y !== e.y || last_seg !== e.last) begin
                    errors++;
                    $display("%0t mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                             $time, e.x, e.y, e.last, line_x, line_y, last_seg);
                end
            end
        end
    end

    task automatic write_limit(logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(REG_FLATNESS_LIMIT) << 2; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        model_limit = value[LIMIT_WIDTH-1:0];
    endtask

    // Hold until the queue is drained and all points are back, then settle.
    task automatic drain();
        while (curve_queue.size() > 0 || in_valid || segment_queue.size() > 0)
            @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd_coord(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 4000)) - 2000;
        endcase
    endfunction

    task automatic add_curve(logic signed [31:0] a0, a1, a2, a3, a4, a5, a6, a7);
        t_curve cv;
        cv.c[0] = a0; cv.c[1] = a1; cv.c[2] = a2; cv.c[3] = a3;
        cv.c[4] = a4; cv.c[5] = a5; cv.c[6] = a6; cv.c[7] = a7;
        curve_queue.push_back(cv);
    endtask

    task automatic add_random(int n);
        t_curve cv;
        int style;
        for (int k = 0; k < n; k++) begin
            style = $urandom_range(0, 9);
            style = (style < 2) ? 0 : (style < 7) ? 1 : (style < 8) ? 2 : 3;
            foreach (cv.c[i]) cv.c[i] = ($urandom_range(0, 7) == 0) ? rnd_coord(0)
                                                                     : rnd_coord(style);
            curve_queue.push_back(cv);
        end
    endtask

    localparam logic signed [31:0] MAXC = 32'sh7fffffff;
    localparam logic signed [31:0] MINC = 32'sh80000000;

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: degenerate, straight, extreme and forced-depth curves.
        add_curve(0, 0, 0, 0, 0, 0, 0, 0);
        add_curve(0, 0, 32'h10000, 0, 32'h20000, 0, 32'h30000, 0);
        add_curve(0, 0, 32'h10000, 32'h40000, 32'h20000, 32'h40000, 32'h30000, 0);
        add_curve(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
        add_curve(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC);
        add_curve(MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, MINC);
        add_curve(MAXC, MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC);
        add_curve(-1, -1, 1, 1, -1, -1, 1, 1);
        add_curve(0, 0, 32'h01000000, 0, 0, 32'h01000000, 32'h01000000, 32'h01000000);
        add_curve(32'h12345678, -32'sh1234, 32'h55aa55aa, 32'haa55aa55,
                  32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333, 32'hcccccccc);
        drain();

        // Tight limit: most curves hit the depth bound.
        write_limit(0);
        add_random(60);
        // Hold the receiver off while the sender keeps going.
        repeat (50) @(posedge i_clk);
        long_hold = 1'b1;
        @(posedge i_clk);
        long_hold = 1'b0;
        drain();

        write_limit(32'h7fffffff);
        add_curve(MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC);
        add_random(60);
        drain();

        write_limit(32'h00001000);
        add_random(70);
        drain();

        write_limit(32'h0004_0000);
        add_random(70);
        drain();

        write_limit(LIMIT_RESET);
        add_random(60);
        drain();

        $display("%0d curves driven, %0d line points checked over five limit settings",
                 curves_sent, segments_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors", errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/cbf_pkg.sv
hdl/cbf_datapath.sv
hdl/cbf_controller.sv
hdl/cubic_bezier_flattener.sv
dv/cubic_bezier_flattener_tb.sv
